// ===== hw/rtl/dpau_pkg.sv =====
// Shared types, constants and the log table builder for the dew point converter.
package dpau_pkg;

  // Fixed-point format of the dew point datapath
  localparam int FRAC_BITS = 16;
  localparam int LN_DEPTH = 1024;
  localparam int LN_AW = $clog2(LN_DEPTH);
  localparam int HUMI_FULL = 1000;

  // Magnus constant a in Q format, b is folded in as 237.7 * 10
  localparam longint A_FX = ((64'd17271 << FRAC_BITS) + 64'd500) / 64'd1000;
  localparam int B_TENTHS = 2377;
  localparam int DEW_SCALE = 23770;
  localparam longint LN2_Q30 = 64'd744261118;
  localparam int DEW_MIN_MAG = 9999;
  localparam int DEW_MAX = 8000;

  // Widths of the datapath
  localparam int LN_W = FRAC_BITS + 4;          // ln(h/1000), signed
  localparam int A_W = FRAC_BITS + 5;           // a in Q format, unsigned
  localparam int P1_W = A_W + 12;               // a * t, signed
  localparam int N1_W = P1_W;                   // 2|a*t| + (b+t)
  localparam int Q1_W = FRAC_BITS + 4;          // |a*t/(b+t)|
  localparam int G_W = FRAC_BITS + 6;           // g, signed
  localparam int P2_W = FRAC_BITS + 22;         // 23770 * g, signed
  localparam int N2_W = P2_W + 1;               // 2|num| + den
  localparam int Q2_W = 15;                     // |dew| before clamping
  localparam int REM_W = FRAC_BITS + 7;         // divisor and remainder
  localparam int SHR_W = (Q1_W > Q2_W) ? Q1_W : Q2_W;
  localparam int LATENCY = Q1_W + Q2_W + 6;

  // Per-transaction payload carried along the divider rows
  typedef struct packed {
    logic [15:0]     fahr;
    logic [15:0]     kelv;
    logic            invalid;
    logic            neg;
    logic [LN_W-1:0] ln;
  } side_t;

  // State held by one divider cell
  typedef struct packed {
    logic             valid;
    logic [REM_W-1:0] rem;
    logic [REM_W-1:0] den;
    logic [SHR_W-1:0] shr;
    side_t            side;
  } cell_t;

  typedef logic signed [LN_W-1:0] ln_table_t [LN_DEPTH];

  // log2 in Q30 by repeated squaring of the normalized mantissa
  function automatic logic [63:0] log2_q30(input logic [31:0] v);
    logic [63:0] m;
    logic [63:0] r;
    int e;
    e = 0;
    for (int i = 1; i < 32; i++) begin
      if ((v >> i) != 32'd0) e = i;
    end
    m = 64'(v) << (30 - e);
    r = 64'(e) << 30;
    for (int i = 29; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

  // ln(h/1000) in Q format, zero outside 1..1000
  function automatic ln_table_t build_ln_table();
    ln_table_t tab;
    logic [63:0] lfull;
    logic [63:0] d;
    logic [63:0] p;
    logic [63:0] mag;
    lfull = log2_q30(32'(HUMI_FULL));
    for (int h = 0; h < LN_DEPTH; h++) begin
      if (h >= 1 && h <= HUMI_FULL) begin
        d = lfull - log2_q30(32'(h));
        p = d * 64'(LN2_Q30);
        mag = (p + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
        tab[h] = -$signed(LN_W'(mag));
      end else begin
        tab[h] = '0;
      end
    end
    return tab;
  endfunction

endpackage

// ===== hw/rtl/dpau_ln_rom.sv =====
// Registered-read ROM of ln(h/1000) over the humidity code.
module dpau_ln_rom
  import dpau_pkg::*;
(
  input  logic                   clk,
  input  logic [LN_AW-1:0]       addr,
  output logic signed [LN_W-1:0] data
);

  localparam ln_table_t LN_TABLE = build_ln_table();

  // Synchronous read
  always_ff @(posedge clk) begin
    data <= LN_TABLE[addr];
  end

endmodule

// ===== hw/rtl/dpau_div_cell.sv =====
// One restoring divider cell: retires one quotient bit per transaction.
module dpau_div_cell
  import dpau_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  cell_t din,
  output cell_t dout
);

  logic [REM_W:0] sh;
  logic [REM_W:0] diff;
  logic           take;

  // Bring in the next numerator bit and try the subtract
  always_comb begin
    sh   = {din.rem, din.shr[SHR_W-1]};
    diff = sh - {1'b0, din.den};
    take = (sh >= {1'b0, din.den});
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
  end

  // Payload: quotient bit shifts in where numerator bits leave
  always_ff @(posedge clk) begin
    dout.rem  <= take ? diff[REM_W-1:0] : sh[REM_W-1:0];
    dout.den  <= din.den;
    dout.shr  <= {din.shr[SHR_W-2:0], take};
    dout.side <= din.side;
  end

endmodule

// ===== hw/rtl/dew_point_and_unit_converter.sv =====
// Top level: Fahrenheit, Kelvin and Magnus dew point per reading.
// Registers from accept to done: stages A and B, divider row 1, stages C, D and E, divider row 2, output stage.
// Throughput: one transaction per cycle; busy stays low, start is always taken.
// The two rounded divisions run as rows of one-bit cells (20 and 15 cells).
// Reset clears only the valid bits of the pipeline; no results follow reset.
// The receiver cannot stall: each result shows for exactly one cycle with done.
module dew_point_and_unit_converter
  import dpau_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [10:0] temperature_tenths,
  input  logic [9:0]         humidity_tenths,
  output logic               done,
  output logic signed [14:0] dew_point_hundredths,
  output logic signed [15:0] fahrenheit_hundredths,
  output logic [15:0]        kelvin_hundredths,
  output logic               humidity_invalid
);

  localparam logic signed [P1_W-1:0] A_P1 = P1_W'(A_FX);
  localparam logic signed [G_W:0] A_G = (G_W + 1)'(A_FX);
  localparam logic signed [P2_W-1:0] SCALE_P2 = P2_W'(DEW_SCALE);

  logic                   accept;
  logic [LN_AW-1:0]       h_addr;
  logic signed [LN_W-1:0] ln_rd;

  // Stage A
  logic                   a_valid;
  logic signed [P1_W-1:0] a_prod;
  logic [11:0]            a_den;
  logic [15:0]            a_fahr;
  logic [15:0]            a_kelv;
  logic                   a_invalid;

  // Divider rows
  cell_t c1 [Q1_W+1];
  cell_t c2 [Q2_W+1];

  logic [P1_W-1:0] mag1;
  logic [N1_W-1:0] n1;

  // Stage C: g
  logic                  g_valid;
  logic signed [G_W-1:0] g;
  side_t                 g_side;
  logic [Q1_W-1:0]       q1;
  logic signed [G_W-1:0] g_next;

  // Stage D: dew numerator and denominator
  logic                   d_valid;
  logic signed [P2_W-1:0] d_prod;
  logic [REM_W-1:0]       d_den;
  side_t                  d_side;
  logic signed [G_W:0]    den2;

  logic [P2_W-1:0] mag2;
  logic [N2_W-1:0] n2;

  logic [Q2_W-1:0]  q2;
  logic signed [14:0] dew_next;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Humidity above full scale reads as 100 percent
  assign h_addr = (humidity_tenths > 10'(HUMI_FULL)) ? LN_AW'(HUMI_FULL)
                                                    : LN_AW'(humidity_tenths);

  dpau_ln_rom u_ln_rom (
    .clk  (clk),
    .addr (h_addr),
    .data (ln_rd)
  );

  // Stage A: unit conversions and a*t
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    a_prod    <= P1_W'(temperature_tenths) * A_P1;
    a_den     <= 12'(13'(temperature_tenths) + 13'(B_TENTHS));
    a_fahr    <= 16'(17'(temperature_tenths) * 17'sd18 + 17'sd3200);
    a_kelv    <= 16'(17'(temperature_tenths) * 17'sd10 + 17'sd27315);
    a_invalid <= (humidity_tenths == 10'd0);
  end

  // Stage B: rounded-division operands for a*t/(b+t)
  always_comb begin
    mag1 = a_prod[P1_W-1] ? P1_W'(-a_prod) : P1_W'(a_prod);
    n1   = {mag1[P1_W-2:0], 1'b0} + N1_W'(a_den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1[0].valid <= 1'b0;
    end else begin
      c1[0].valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    c1[0].rem          <= REM_W'(n1 >> Q1_W);
    c1[0].den          <= REM_W'({a_den, 1'b0});
    c1[0].shr          <= SHR_W'(n1[Q1_W-1:0]) << (SHR_W - Q1_W);
    c1[0].side.fahr    <= a_fahr;
    c1[0].side.kelv    <= a_kelv;
    c1[0].side.invalid <= a_invalid;
    c1[0].side.neg     <= a_prod[P1_W-1];
    c1[0].side.ln      <= ln_rd;
  end

  for (genvar i = 0; i < Q1_W; i++) begin : g_row1
    dpau_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (c1[i]),
      .dout (c1[i+1])
    );
  end

  // Stage C: g = a*t/(b+t) + ln(RH)
  always_comb begin
    q1     = c1[Q1_W].shr[Q1_W-1:0];
    g_next = (c1[Q1_W].side.neg ? -$signed(G_W'(q1)) : $signed(G_W'(q1)))
             + G_W'($signed(c1[Q1_W].side.ln));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else begin
      g_valid <= c1[Q1_W].valid;
    end
  end

  always_ff @(posedge clk) begin
    g      <= g_next;
    g_side <= c1[Q1_W].side;
  end

  // Stage D: 100*b*g and a - g (always positive over the input range)
  assign den2 = A_G - (G_W + 1)'(g);

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else begin
      d_valid <= g_valid;
    end
  end

  always_ff @(posedge clk) begin
    d_prod <= P2_W'(g) * SCALE_P2;
    d_den  <= REM_W'({den2[G_W-1:0], 1'b0});
    d_side <= g_side;
  end

  // Stage E: rounded-division operands for the dew point
  always_comb begin
    mag2 = d_prod[P2_W-1] ? P2_W'(-d_prod) : P2_W'(d_prod);
    n2   = {mag2, 1'b0} + N2_W'(d_den >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c2[0].valid <= 1'b0;
    end else begin
      c2[0].valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    c2[0].rem          <= REM_W'(n2 >> Q2_W);
    c2[0].den          <= d_den;
    c2[0].shr          <= SHR_W'(n2[Q2_W-1:0]) << (SHR_W - Q2_W);
    c2[0].side.fahr    <= d_side.fahr;
    c2[0].side.kelv    <= d_side.kelv;
    c2[0].side.invalid <= d_side.invalid;
    c2[0].side.neg     <= d_prod[P2_W-1];
    c2[0].side.ln      <= '0;
  end

  for (genvar i = 0; i < Q2_W; i++) begin : g_row2
    dpau_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (c2[i]),
      .dout (c2[i+1])
    );
  end

  // Output stage: sign, saturation, invalid override
  always_comb begin
    q2 = c2[Q2_W].shr[Q2_W-1:0];
    if (c2[Q2_W].side.invalid) begin
      dew_next = '0;
    end else if (c2[Q2_W].side.neg) begin
      dew_next = (q2 > Q2_W'(DEW_MIN_MAG)) ? -15'sd9999 : -$signed(q2);
    end else begin
      dew_next = (q2 > Q2_W'(DEW_MAX)) ? 15'sd8000 : $signed(q2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= c2[Q2_W].valid;
    end
  end

  always_ff @(posedge clk) begin
    dew_point_hundredths  <= dew_next;
    fahrenheit_hundredths <= $signed(c2[Q2_W].side.fahr);
    kelvin_hundredths     <= c2[Q2_W].side.kelv;
    humidity_invalid      <= c2[Q2_W].side.invalid;
  end

  // Every accepted transaction yields exactly one result after fixed latency
  a_lat_fwd: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("result missing after accepted transaction");

  a_lat_back: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result without matching transaction");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && humidity_invalid) |-> (dew_point_hundredths == 15'sd0))
    else $error("invalid humidity with nonzero dew point");

  a_dew_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (dew_point_hundredths >= -15'sd9999 && dew_point_hundredths <= 15'sd8000))
    else $error("dew point outside saturation range");

endmodule

// ===== tb/dew_point_and_unit_converter_tb.sv =====
// Testbench for the dew point and unit converter: directed and random readings.
module dew_point_and_unit_converter_tb;
  import dpau_pkg::*;

  localparam int DRAIN_CYCLES = 60;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic signed [14:0] dew;
    logic signed [15:0] fahr;
    logic [15:0]        kelv;
    logic               invalid;
  } reading_result_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic signed [10:0] temperature_tenths;
  logic [9:0]         humidity_tenths;
  logic               done;
  logic signed [14:0] dew_point_hundredths;
  logic signed [15:0] fahrenheit_hundredths;
  logic [15:0]        kelvin_hundredths;
  logic               humidity_invalid;

  reading_result_t pending_results[$];
  longint          ln_of_humidity[1001];
  int              error_count;
  int              readings_sent;
  int              results_seen;
  int              invalid_seen;
  int              idle_cycles;

  dew_point_and_unit_converter dut (
    .clk                   (clk),
    .rst                   (rst),
    .start                 (start),
    .busy                  (busy),
    .temperature_tenths    (temperature_tenths),
    .humidity_tenths       (humidity_tenths),
    .done                  (done),
    .dew_point_hundredths  (dew_point_hundredths),
    .fahrenheit_hundredths (fahrenheit_hundredths),
    .kelvin_hundredths     (kelvin_hundredths),
    .humidity_invalid      (humidity_invalid)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // log2 with 30 fraction bits by squaring the normalized mantissa
  function automatic longint unsigned log2_fixed30(int unsigned v);
    longint unsigned mant;
    longint unsigned acc;
    int              msb;
    msb = 0;
    while (msb < 31 && (v >> (msb + 1)) != 0) msb++;
    mant = longint'(v) << (30 - msb);
    acc = longint'(msb) << 30;
    for (int i = 29; i >= 0; i--) begin
      mant = (mant * mant) >> 30;
      if (mant >= (64'd2 << 30)) begin
        mant = mant >> 1;
        acc = acc | (64'd1 << i);
      end
    end
    return acc;
  endfunction

  // ln(h/1000) table in Q format
  task automatic fill_ln_of_humidity();
    longint unsigned full_log;
    longint unsigned diff;
    longint unsigned prod;
    full_log = log2_fixed30(HUMI_FULL);
    ln_of_humidity[0] = 0;
    for (int h = 1; h <= HUMI_FULL; h++) begin
      diff = full_log - log2_fixed30(h);
      prod = diff * 64'd744261118;
      ln_of_humidity[h] =
        -longint'((prod + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS));
    end
  endtask

  // Divide rounding to nearest, halves away from zero; divisor positive
  function automatic longint round_div(longint num, longint den);
    longint unsigned mag;
    longint unsigned q;
    mag = num < 0 ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic reading_result_t predict_reading(logic signed [10:0] t_in,
                                                      logic [9:0] h_in);
    reading_result_t r;
    longint t;
    longint a_q;
    longint g;
    longint den;
    longint dew;
    int     h;
    t = t_in;
    h = h_in;
    a_q = ((64'd17271 << FRAC_BITS) + 500) / 1000;
    dew = 0;
    r.fahr = 16'(t * 18 + 3200);
    r.kelv = 16'(t * 10 + 27315);
    r.invalid = (h == 0);
    if (h != 0) begin
      if (h > HUMI_FULL) h = HUMI_FULL;
      g = round_div(a_q * t, 2377 + t) + ln_of_humidity[h];
      den = a_q - g;
      if (den <= 0) begin
        dew = 8000;
      end else begin
        dew = round_div(23770 * g, den);
        if (dew < -9999) dew = -9999;
        if (dew > 8000) dew = 8000;
      end
    end
    r.dew = 15'(dew);
    return r;
  endfunction

  // Send one reading, after a random gap unless gaps is clear; queue its expected result
  task automatic send_reading(logic signed [10:0] t, logic [9:0] h, bit gaps = 1);
    int gap;
    gap = gaps ? $urandom_range(7, 0) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    temperature_tenths <= t;
    humidity_tenths <= h;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_reading(t, h));
    readings_sent++;
  endtask

  task automatic stop_sending();
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    stop_sending();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    reading_result_t want;
    if (!rst && done) begin
      results_seen++;
      if (humidity_invalid) invalid_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no transaction outstanding");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (dew_point_hundredths !== want.dew) begin
          $error("dew_point_hundredths: expected %0d, got %0d", want.dew,
                 dew_point_hundredths);
          error_count++;
        end
        if (fahrenheit_hundredths !== want.fahr) begin
          $error("fahrenheit_hundredths: expected %0d, got %0d", want.fahr,
                 fahrenheit_hundredths);
          error_count++;
        end
        if (kelvin_hundredths !== want.kelv) begin
          $error("kelvin_hundredths: expected %0d, got %0d", want.kelv,
                 kelvin_hundredths);
          error_count++;
        end
        if (humidity_invalid !== want.invalid) begin
          $error("humidity_invalid: expected %0b, got %0b", want.invalid,
                 humidity_invalid);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted transaction or result
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("dew_point_and_unit_converter_tb: errors");
        $finish;
      end
    end
  end

  // Field extremes, zero and saturated humidity, full-scale bit patterns
  task automatic test_directed_extremes();
    send_reading(-400, 1);
    send_reading(800, 1000);
    send_reading(-400, 1000);
    send_reading(800, 1);
    send_reading(0, 0);
    send_reading(250, 0);
    send_reading(-1024, 500);
    send_reading(1023, 1000);
    send_reading(-1024, 1);
    send_reading(1023, 1);
    send_reading(200, 1001);
    send_reading(200, 1023);
    send_reading(0, 1000);
    send_reading(-1, 999);
    send_reading(-2, 512);
    send_reading(350, 650);
    send_reading(-1024, 0);
    send_reading(1023, 0);
    send_reading(-200, 10);
    send_reading(600, 50);
  endtask

  // Back-to-back readings with no gaps
  task automatic test_back_to_back();
    for (int i = 0; i < 200; i++) begin
      send_reading(11'($urandom_range(1200, 0) - 400), 10'($urandom_range(1000, 0)), 0);
    end
  endtask

  // Random readings: mostly in range, some covering every bit pattern
  task automatic test_random_readings(int count);
    logic signed [10:0] t;
    logic [9:0]         h;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9, 0) < 8) begin
        t = 11'($urandom_range(1200, 0) - 400);
        h = ($urandom_range(19, 0) == 0) ? 10'd0 : 10'($urandom_range(1000, 1));
      end else begin
        t = 11'($urandom);
        h = 10'($urandom);
      end
      if ($urandom_range(3, 0) == 0) send_reading(t, h, 0);
      else send_reading(t, h);
    end
  endtask

  initial begin
    error_count = 0;
    readings_sent = 0;
    results_seen = 0;
    invalid_seen = 0;
    idle_cycles = 0;
    rst = 1'b1;
    start = 1'b0;
    temperature_tenths = '0;
    humidity_tenths = '0;
    fill_ln_of_humidity();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_extremes();
    wait_drained();
    test_back_to_back();
    test_random_readings(850);
    // hold off until the pipeline is empty, then continue
    wait_drained();
    test_random_readings(880);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d readings, %0d results, %0d with zero humidity.",
             readings_sent, results_seen, invalid_seen);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("dew_point_and_unit_converter_tb: clean");
    end else begin
      $display("dew_point_and_unit_converter_tb: errors");
    end
    $finish;
  end

endmodule
